// ===== src/bse_pkg.sv =====
// bse_pkg: shared types and constants for the background subtraction engine
// no dependencies
`default_nettype none
package bse_pkg;
    localparam int unsigned REG_IDX_W = 3;

    // fraction bits of the window reciprocal
    localparam int unsigned RECIP_SH = 13;

    typedef enum logic [REG_IDX_W-1:0] {
        REG_TH_PREV   = 3'd0,
        REG_TH_WINDOW = 3'd1,
        REG_TH_EXP    = 3'd2,
        REG_WINDOW_K  = 3'd3,
        REG_ALPHA     = 3'd4
    } t_reg_idx;

    typedef enum logic [3:0] {
        ST_IDLE  = 4'b0001,
        ST_READ  = 4'b0010,
        ST_ACCUM = 4'b0100,
        ST_OUT   = 4'b1000
    } t_state;

    function automatic logic [7:0] fg_of(input logic [7:0] p, input logic [7:0] bg,
                                         input logic [7:0] th);
        logic [7:0] d;
        d = (p >= bg) ? (p - bg) : (bg - p);
        return (d > th) ? d : 8'd0;
    endfunction

    // ceil(2^13 / k) for k = 1..31, so (p * recip) >> 13 equals floor(p / k) for 8-bit p
    function automatic logic [13:0] win_recip(input logic [4:0] k);
        logic [13:0] m;
        case (k)
            5'd2:    m = 14'd4096;
            5'd3:    m = 14'd2731;
            5'd4:    m = 14'd2048;
            5'd5:    m = 14'd1639;
            5'd6:    m = 14'd1366;
            5'd7:    m = 14'd1171;
            5'd8:    m = 14'd1024;
            5'd9:    m = 14'd911;
            5'd10:   m = 14'd820;
            5'd11:   m = 14'd745;
            5'd12:   m = 14'd683;
            5'd13:   m = 14'd631;
            5'd14:   m = 14'd586;
            5'd15:   m = 14'd547;
            5'd16:   m = 14'd512;
            5'd17:   m = 14'd482;
            5'd18:   m = 14'd456;
            5'd19:   m = 14'd432;
            5'd20:   m = 14'd410;
            5'd21:   m = 14'd391;
            5'd22:   m = 14'd373;
            5'd23:   m = 14'd357;
            5'd24:   m = 14'd342;
            5'd25:   m = 14'd328;
            5'd26:   m = 14'd316;
            5'd27:   m = 14'd304;
            5'd28:   m = 14'd293;
            5'd29:   m = 14'd283;
            5'd30:   m = 14'd274;
            5'd31:   m = 14'd265;
            default: m = 14'd8192;
        endcase
        return m;
    endfunction
endpackage
`default_nettype wire

// ===== src/bse_ram.sv =====
// bse_ram: generic single-port-write, single-port-read ram, registered read
// no dependencies
`default_nettype none
module bse_ram #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 256
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) r_mem[i_waddr] <= i_wdata;
        o_rdata <= r_mem[i_raddr];
    end
endmodule
`default_nettype wire

// ===== src/background_subtraction_engine.sv =====
// background_subtraction_engine: top level, sequencer and three background models
// depends on bse_pkg and bse_ram
`default_nettype none
// One pixel per beat in raster order, last_in_frame on tlast. Each pixel is
// handled by a sequencer: a read step for the previous-frame and
// exponential stores, then one window-ring read per past frame (k reads, only
// once frame_count has reached k; k is the clamped window length), then the
// accumulate step takes the last read data and the result goes to an output
// register, which may wait on m_axis_tready. The window reads follow one
// another through the single read port of the window ring memory, which
// holds MAX_K frames side by side. Stores are not cleared: the first frame
// gives zeros for the previous and exponential models, and the window model
// gives zeros until k frames are stored. A new pixel is accepted while the
// previous result still waits in the output register, but only once the
// sequencer is back in idle.
module background_subtraction_engine
    import bse_pkg::*;
#(
    parameter int unsigned MAX_PIXELS = 65536,
    parameter int unsigned MAX_K      = 16
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 s_axis_tvalid,
    output logic                      s_axis_tready,
    input  wire logic [7:0]           s_axis_tdata,   // pixel
    input  wire logic                 s_axis_tlast,   // last_in_frame
    output logic                      m_axis_tvalid,
    input  wire logic                 m_axis_tready,
    output logic [47:0]               m_axis_tdata,   // fg_prev, bg_prev, fg_window,
                                                      // bg_window, fg_exp, bg_exp
    output logic                      m_axis_tlast,   // frame_end
    input  wire logic                 i_cfg_valid,
    output logic                      o_cfg_ready,
    input  wire logic [REG_IDX_W-1:0] i_cfg_index,
    input  wire logic [8:0]           i_cfg_data
);
    localparam int unsigned PW = (MAX_PIXELS > 1) ? $clog2(MAX_PIXELS) : 1;
    localparam int unsigned SW = (MAX_K > 1) ? $clog2(MAX_K) : 1;
    localparam int unsigned KW = $clog2(MAX_K + 1);
    localparam int unsigned WD = MAX_K * MAX_PIXELS;
    localparam int unsigned WW = $clog2(WD);

    // configuration
    logic [7:0] r_th_prev, r_th_win, r_th_exp;
    logic [4:0] r_win_k;
    logic [8:0] r_alpha;
    assign o_cfg_ready = 1'b1;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_th_prev <= 8'd50; r_th_win <= 8'd20; r_th_exp <= 8'd5;
            r_win_k <= 5'd10; r_alpha <= 9'd128;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                REG_TH_PREV:   r_th_prev <= i_cfg_data[7:0];
                REG_TH_WINDOW: r_th_win  <= i_cfg_data[7:0];
                REG_TH_EXP:    r_th_exp  <= i_cfg_data[7:0];
                REG_WINDOW_K:  r_win_k   <= i_cfg_data[4:0];
                REG_ALPHA:     r_alpha   <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // clamped k and alpha
    logic [KW-1:0] k_eff;
    logic [8:0]    a_eff;
    always_comb begin
        if (r_win_k == 5'd0) k_eff = KW'(1);
        else if (32'(r_win_k) > MAX_K) k_eff = KW'(MAX_K);
        else k_eff = KW'(r_win_k);
        a_eff = (r_alpha > 9'd256) ? 9'd256 : r_alpha;
    end

    t_state          r_state;
    logic [PW-1:0]   r_pos;
    logic [KW-1:0]   r_fcnt;
    logic [SW-1:0]   r_slot;
    logic [7:0]      r_pix;
    logic            r_last;
    logic [KW-1:0]   r_j;       // window reads issued
    logic [KW-1:0]   r_k;       // k latched for this pixel
    logic            r_rd_pend;
    logic [11:0]     r_sum;
    logic            r_wfull, r_first;
    logic [7:0]      r_exp_hold, r_bgp_hold;

    logic [7:0] prev_rd, exp_rd, win_rd;
    logic       out_free;
    assign out_free = !m_axis_tvalid || m_axis_tready;
    assign s_axis_tready = (r_state == ST_IDLE);

    // window read address: slot - j - 1 modulo MAX_K
    logic [31:0]   rd_slot_raw;
    logic [SW-1:0] rd_slot;
    assign rd_slot_raw = 32'(r_slot) + MAX_K - 32'(r_j) - 1;
    assign rd_slot = SW'((rd_slot_raw >= MAX_K) ? rd_slot_raw - MAX_K : rd_slot_raw);
    logic [WW-1:0] win_raddr, win_waddr;
    assign win_raddr = WW'(32'(rd_slot) * MAX_PIXELS + 32'(r_pos));
    assign win_waddr = WW'(32'(r_slot) * MAX_PIXELS + 32'(r_pos));

    // exponential background, one multiply per term
    logic [16:0] e_mix;
    logic [7:0]  bg_e;
    assign e_mix = 17'(a_eff) * 17'(exp_rd) + 17'(9'd256 - a_eff) * 17'(prev_rd);
    assign bg_e  = r_first ? 8'd0 : e_mix[15:8];

    // floor(p / k) by reciprocal multiplication
    logic [21:0] win_prod;
    logic [7:0]  bg_p, bg_w, win_div;
    assign bg_p     = r_first ? 8'd0 : prev_rd;
    assign win_prod = 22'(win_rd) * 22'(win_recip(5'(r_k)));
    assign win_div  = win_prod[RECIP_SH+7:RECIP_SH];
    assign bg_w     = r_wfull ? r_sum[7:0] : 8'd0;

    logic wr_en;
    assign wr_en = (r_state == ST_OUT) && out_free;

    bse_ram #(.WIDTH(8), .DEPTH(MAX_PIXELS)) u_prev (
        .i_clk, .i_we(wr_en), .i_waddr(r_pos), .i_wdata(r_pix),
        .i_raddr(r_pos), .o_rdata(prev_rd));
    bse_ram #(.WIDTH(8), .DEPTH(MAX_PIXELS)) u_exp (
        .i_clk, .i_we(wr_en), .i_waddr(r_pos), .i_wdata(r_exp_hold),
        .i_raddr(r_pos), .o_rdata(exp_rd));
    bse_ram #(.WIDTH(8), .DEPTH(WD)) u_win (
        .i_clk, .i_we(wr_en), .i_waddr(win_waddr), .i_wdata(r_pix),
        .i_raddr(win_raddr), .o_rdata(win_rd));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE; r_pos <= '0; r_fcnt <= '0; r_slot <= '0;
            m_axis_tvalid <= 1'b0; r_rd_pend <= 1'b0;
        end else begin
            // a result beat leaves unless a new one is loaded below
            if (m_axis_tvalid && m_axis_tready && r_state != ST_OUT)
                m_axis_tvalid <= 1'b0;
            unique case (r_state)
                ST_IDLE: begin
                    if (s_axis_tvalid) begin
                        r_pix <= s_axis_tdata; r_last <= s_axis_tlast;
                        r_first <= (r_fcnt == '0);
                        r_wfull <= (r_fcnt >= k_eff);
                        r_k <= k_eff; r_j <= '0; r_sum <= '0;
                        r_state <= ST_READ;
                    end
                end
                ST_READ: begin
                    // store reads complete this cycle
                    r_rd_pend <= 1'b0;
                    r_state <= ST_ACCUM;
                end
                ST_ACCUM: begin
                    if (r_j == '0 && !r_rd_pend) begin
                        r_exp_hold <= bg_e; r_bgp_hold <= bg_p;
                    end
                    if (r_rd_pend) r_sum <= r_sum + 12'(win_div);
                    if (r_wfull && r_j != r_k) begin
                        r_j <= r_j + 1'b1; r_rd_pend <= 1'b1;
                    end else if (!r_rd_pend || !r_wfull) begin
                        r_rd_pend <= 1'b0; r_state <= ST_OUT;
                    end else begin
                        r_rd_pend <= 1'b0;
                    end
                end
                ST_OUT: begin
                    if (out_free) begin
                        m_axis_tvalid <= 1'b1;
                        m_axis_tdata <= {r_exp_hold,
                                         r_first ? 8'd0 : fg_of(r_pix, r_exp_hold, r_th_exp),
                                         bg_w, fg_of(r_pix, bg_w, r_th_win) & {8{r_wfull}},
                                         r_bgp_hold,
                                         r_first ? 8'd0 : fg_of(r_pix, r_bgp_hold, r_th_prev)};
                        m_axis_tlast <= r_last;
                        if (r_last) begin
                            r_pos <= '0;
                            if (32'(r_fcnt) < MAX_K) r_fcnt <= r_fcnt + 1'b1;
                            r_slot <= (32'(r_slot) == MAX_K - 1) ? '0 : r_slot + 1'b1;
                        end else begin
                            r_pos <= (32'(r_pos) == MAX_PIXELS - 1) ? '0 : r_pos + 1'b1;
                        end
                        r_state <= ST_IDLE;
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end
endmodule
`default_nettype wire

// ===== tb/testbench.sv =====
// testbench: self-checking bench for background_subtraction_engine
// drives pixel frames and register writes, predicts all three background models
// depends on bse_pkg and the engine rtl
`timescale 1ns / 1ps

module testbench;
    import bse_pkg::*;

    localparam int unsigned FRAME_LEN  = 6;     // fixed frame length, so no unwritten store reads
    localparam int unsigned RING_DEPTH = 16;
    localparam int unsigned WDOG_LIMIT = 3000;
    localparam int unsigned HOLD_LEN   = 400;
    localparam int unsigned DRAIN_WAIT = 40;
    localparam logic [REG_IDX_W-1:0] REG_IDX_UNMAPPED = 3'd7;

    // one expected output beat
    typedef struct packed {
        logic [7:0] fg_prev;
        logic [7:0] bg_prev;
        logic [7:0] fg_win;
        logic [7:0] bg_win;
        logic [7:0] fg_exp;
        logic [7:0] bg_exp;
        logic       frame_end;
    } t_bgs_result;

    // predictor of the three models plus the queue of pending results
    class bgs_scoreboard;
        logic [7:0]  th_prev, th_win, th_exp;
        logic [4:0]  win_k;
        logic [8:0]  alpha;
        logic [7:0]  last_frame [FRAME_LEN];
        logic [7:0]  exp_bg [FRAME_LEN];
        logic [7:0]  ring [RING_DEPTH][FRAME_LEN];
        int unsigned pos, frames_seen, ring_slot;
        t_bgs_result pending_q [$];
        int unsigned errors;

        function void clear();
            th_prev = 8'd50; th_win = 8'd20; th_exp = 8'd5;
            win_k = 5'd10; alpha = 9'd128;
            pos = 0; frames_seen = 0; ring_slot = 0; errors = 0;
        endfunction

        function void write_reg(logic [REG_IDX_W-1:0] idx, logic [8:0] val);
            case (idx)
                REG_TH_PREV:   th_prev = val[7:0];
                REG_TH_WINDOW: th_win  = val[7:0];
                REG_TH_EXP:    th_exp  = val[7:0];
                REG_WINDOW_K:  win_k   = val[4:0];
                REG_ALPHA:     alpha   = val;
                default: ;
            endcase
        endfunction

        function logic [7:0] fg_diff(logic [7:0] p, logic [7:0] bg, logic [7:0] th);
            logic [7:0] d;
            d = (p >= bg) ? p - bg : bg - p;
            return (d > th) ? d : 8'd0;
        endfunction

        function void note_pixel(logic [7:0] p, logic last);
            t_bgs_result r;
            int unsigned k, a, sum;
            r = '0;
            k = (win_k == 0) ? 1 : ((win_k > RING_DEPTH) ? RING_DEPTH : win_k);
            a = (alpha > 256) ? 256 : alpha;
            if (frames_seen != 0) begin
                r.bg_prev = last_frame[pos];
                r.fg_prev = fg_diff(p, r.bg_prev, th_prev);
                r.bg_exp  = 8'((a * exp_bg[pos] + (256 - a) * last_frame[pos]) >> 8);
                r.fg_exp  = fg_diff(p, r.bg_exp, th_exp);
            end
            if (frames_seen >= k) begin
                sum = 0;
                for (int j = 1; j <= k; j++)
                    sum += ring[(ring_slot + RING_DEPTH - j) % RING_DEPTH][pos] / k;
                r.bg_win = 8'(sum);
                r.fg_win = fg_diff(p, r.bg_win, th_win);
            end
            r.frame_end = last;
            last_frame[pos]      = p;
            exp_bg[pos]          = r.bg_exp;
            ring[ring_slot][pos] = p;
            if (last) begin
                pos = 0;
                if (frames_seen < RING_DEPTH) frames_seen++;
                ring_slot = (ring_slot + 1) % RING_DEPTH;
            end else begin
                pos++;
            end
            pending_q = {pending_q, r};
        endfunction

        function void check_result(logic [47:0] data, logic last);
            t_bgs_result want, got;
            got = {data[7:0], data[15:8], data[23:16], data[31:24],
                   data[39:32], data[47:40], last};
            if (pending_q.size() == 0) begin
                errors++;
                if (errors <= 10) $display("unexpected output beat %h last %b", data, last);
                return;
            end
            want = pending_q.pop_front();
            if (got !== want) begin
                errors++;
                if (errors <= 10)
                    $display("mismatch fgp/bgp %0d/%0d fgw/bgw %0d/%0d fge/bge %0d/%0d end %b,%s",
                             want.fg_prev, want.bg_prev, want.fg_win, want.bg_win,
                             want.fg_exp, want.bg_exp, want.frame_end,
                             $sformatf(" got %0d/%0d %0d/%0d %0d/%0d end %b",
                             got.fg_prev, got.bg_prev, got.fg_win, got.bg_win,
                             got.fg_exp, got.bg_exp, got.frame_end));
            end
        endfunction
    endclass

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 s_axis_tvalid = 1'b0;
    logic                 s_axis_tready;
    logic [7:0]           s_axis_tdata = '0;   // pixel
    logic                 s_axis_tlast = 1'b0; // last_in_frame
    logic                 m_axis_tvalid;
    logic                 m_axis_tready = 1'b0;
    logic [47:0]          m_axis_tdata;        // fg_prev, bg_prev, fg_window, bg_window, fg_exp, bg_exp
    logic                 m_axis_tlast;        // frame_end
    logic                 i_cfg_valid = 1'b0;
    logic                 o_cfg_ready;
    logic [REG_IDX_W-1:0] i_cfg_index = '0;
    logic [8:0]           i_cfg_data = '0;

    bgs_scoreboard sb = new();

    bit          calm;           // no idling on either side while set
    int unsigned hold_tag;       // bumped to make the receiver hold off
    int unsigned idle_cycles;    // cycles since the last accepted beat
    logic [7:0]  frame_buf [FRAME_LEN];

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    background_subtraction_engine dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata), .s_axis_tlast(s_axis_tlast),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata), .m_axis_tlast(m_axis_tlast),
        .i_cfg_valid(i_cfg_valid), .o_cfg_ready(o_cfg_ready),
        .i_cfg_index(i_cfg_index), .i_cfg_data(i_cfg_data)
    );

    // receiver side: random backpressure, plus a long hold-off on request
    int unsigned hold_left = 0;
    int unsigned hold_seen = 0;
    always @(posedge i_clk) begin
        if (hold_tag != hold_seen) begin
            hold_seen = hold_tag;
            hold_left = HOLD_LEN;
        end
        if (hold_left != 0) begin
            hold_left--;
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= calm || ($urandom_range(99) >= 38);
        end
    end

    // output monitor
    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready)
            sb.check_result(m_axis_tdata, m_axis_tlast);
    end

    // watchdog on beats of any kind
    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
            || (i_cfg_valid && o_cfg_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles > WDOG_LIMIT) begin
            $display("tb: failure");
            $finish;
        end
    end

    // one pixel beat; valid stays high when the next beat follows at once
    task automatic send_pixel(input logic [7:0] p, input logic last);
        if (!calm && $urandom_range(99) < 38) begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(4, 1)) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= p;
        s_axis_tlast  <= last;
        do @(posedge i_clk); while (!s_axis_tready);
        sb.note_pixel(p, last);
    endtask

    task automatic stop_pixels();
        s_axis_tvalid <= 1'b0;
        s_axis_tlast  <= 1'b0;
    endtask

    // wait for every pending result, then let the pipeline settle
    task automatic drain();
        stop_pixels();
        while (sb.pending_q.size() != 0) @(posedge i_clk);
        repeat (DRAIN_WAIT) @(posedge i_clk);
    endtask

    // one register beat; valid stays high for a write that follows at once
    task automatic write_reg(input logic [REG_IDX_W-1:0] idx, input logic [8:0] val);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        sb.write_reg(idx, val);
    endtask

    // one frame; pixels near the previous frame hit the thresholds more often
    task automatic send_frame();
        logic [7:0] p;
        for (int n = 0; n < FRAME_LEN; n++) begin
            case ($urandom_range(3))
                0: p = 8'($urandom_range(255));
                1: p = $urandom_range(1) ? 8'hff : 8'h00;
                default: p = frame_buf[n] + 8'($urandom_range(16)) - 8'd8;
            endcase
            frame_buf[n] = p;
            send_pixel(p, n == FRAME_LEN - 1);
        end
    endtask

    // register settings per phase, extremes and out-of-range values included
    logic [7:0] ph_th_prev [8] = '{50, 0, 255, 10, 30, 0, 255, 100};
    logic [7:0] ph_th_win  [8] = '{20, 255, 0, 5, 40, 0, 255, 7};
    logic [7:0] ph_th_exp  [8] = '{5, 0, 255, 3, 20, 255, 0, 60};
    logic [4:0] ph_win_k   [8] = '{10, 1, 16, 0, 31, 4, 16, 2};
    logic [8:0] ph_alpha   [8] = '{128, 0, 256, 511, 300, 64, 200, 255};
    logic [7:0] edge_px    [FRAME_LEN] = '{8'h00, 8'hff, 8'h01, 8'hfe, 8'h80, 8'h7f};

    initial begin
        sb.clear();
        calm = 1'b0;
        hold_tag = 0;
        idle_cycles = 0;
        for (int n = 0; n < FRAME_LEN; n++) frame_buf[n] = 8'h80;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: first frame zeros, extremes swapped frame to frame, reset registers
        for (int f = 0; f < 4; f++)
            for (int n = 0; n < FRAME_LEN; n++)
                send_pixel((f % 2) ? ~edge_px[n] : edge_px[n], n == FRAME_LEN - 1);
        drain();

        for (int ph = 0; ph < 8; ph++) begin
            write_reg(REG_TH_PREV,   ph_th_prev[ph]);
            write_reg(REG_TH_WINDOW, ph_th_win[ph]);
            write_reg(REG_TH_EXP,    ph_th_exp[ph]);
            write_reg(REG_WINDOW_K,  ph_win_k[ph]);
            write_reg(REG_ALPHA,     ph_alpha[ph]);
            if (ph == 3) write_reg(REG_IDX_UNMAPPED, 9'h1ff); // must be ignored
            i_cfg_valid <= 1'b0;
            calm = (ph == 4);
            if (ph == 2) hold_tag++;  // receiver stalls while pixels keep coming
            for (int f = 0; f < 21; f++) send_frame();
            drain();
        end

        if (sb.errors == 0 && sb.pending_q.size() == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end
endmodule
